### rtl/bbc_pkg.sv
`default_nettype none

package bbc_pkg;

  // Default number of stack cells.
  localparam int unsigned StackDepthDefault = 128;

  // Bracket byte codes.
  localparam logic [7:0] CharOpenRound   = 8'h28;  // (
  localparam logic [7:0] CharCloseRound  = 8'h29;  // )
  localparam logic [7:0] CharOpenSquare  = 8'h5B;  // [
  localparam logic [7:0] CharCloseSquare = 8'h5D;  // ]
  localparam logic [7:0] CharOpenCurly   = 8'h7B;  // {
  localparam logic [7:0] CharCloseCurly  = 8'h7D;  // }

  // Kind code held in each stack cell.
  typedef enum logic [1:0] {
    KIND_ROUND  = 2'd0,
    KIND_SQUARE = 2'd1,
    KIND_CURLY  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  // Error code reported with each result item.
  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_MISMATCH = 2'd1,
    ERR_EMPTY    = 2'd2,
    ERR_OPEN     = 2'd3
  } err_e;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic       done_res;
    logic       balanced;
    err_e       error_code;
    logic       overflow_seen;
    logic [7:0] open_depth;
  } out_item_t;

  // Shift control broadcast to every stack cell.
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

  // Kind of an opening bracket, or none.
  function automatic kind_e open_kind(input logic [7:0] b);
    kind_e k;
    unique case (b)
      CharOpenRound:  k = KIND_ROUND;
      CharOpenSquare: k = KIND_SQUARE;
      CharOpenCurly:  k = KIND_CURLY;
      default:        k = KIND_NONE;
    endcase
    return k;
  endfunction

  // Kind of a closing bracket, or none.
  function automatic kind_e close_kind(input logic [7:0] b);
    kind_e k;
    unique case (b)
      CharCloseRound:  k = KIND_ROUND;
      CharCloseSquare: k = KIND_SQUARE;
      CharCloseCurly:  k = KIND_CURLY;
      default:         k = KIND_NONE;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

### rtl/bbc_cell.sv
`default_nettype none

module bbc_cell (
  input  wire logic               clk_i,
  input  wire bbc_pkg::cell_ctrl_t ctrl_i,
  input  wire bbc_pkg::kind_e      above_i,
  input  wire bbc_pkg::kind_e      below_i,
  output bbc_pkg::kind_e           kind_o
);
  import bbc_pkg::*;

  kind_e kind_q;
  kind_e kind_d;

  // A push takes the entry from the cell nearer the top, a pop the one from below.
  always_comb begin
    priority if (ctrl_i.push) begin
      kind_d = above_i;
    end else if (ctrl_i.pop) begin
      kind_d = below_i;
    end else begin
      kind_d = kind_q;
    end
  end

  // Stack payload carries no reset; entries above the fill count are never read.
  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
  end

  assign kind_o = kind_q;

endmodule

`default_nettype wire

### rtl/bracket_balance_checker.sv
// The result of an accepted input item is registered in the output register.
// Throughput: one item per cycle unless the output stalls; the stack is a row of shift cells
// whose top entry sits in the first cell, so a push or pop finishes in the cycle the byte is accepted.
// Reset: fill count, sticky error, overflow flag and output valid clear asynchronously;
// stack cells are not reset. The block accepts items right after reset.
`default_nettype none

module bracket_balance_checker #(
  parameter int unsigned STACK_DEPTH = bbc_pkg::StackDepthDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire bbc_pkg::in_item_t in_item_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  output bbc_pkg::out_item_t     out_item_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i
);
  import bbc_pkg::*;

  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);

  logic [CntW-1:0] count_q, count_d, count_new;
  err_e            failed_q, failed_d, failed_new;
  logic            ovf_q, ovf_d, ovf_new;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_item_q, out_item_d;

  kind_e           kind_w [STACK_DEPTH];
  cell_ctrl_t      cell_ctrl;

  logic            acc;
  kind_e           ok, ck;
  logic            active, full, empty, is_open, is_close;
  err_e            err_res;
  logic [CntW+7:0] depth_ext;

  // The input is taken whenever the output register is empty or being drained.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign acc        = in_valid_i && !in_stall_o;

  // Byte decode and stack status.
  assign ok       = open_kind(in_item_i.char_byte);
  assign ck       = close_kind(in_item_i.char_byte);
  assign active   = (failed_q == ERR_NONE);
  assign full     = (count_q == CntW'(STACK_DEPTH));
  assign empty    = (count_q == '0);
  assign is_open  = active && (ok != KIND_NONE);
  assign is_close = active && (ok == KIND_NONE) && (ck != KIND_NONE);

  // Stack shift control; a push on a full stack is dropped.
  assign cell_ctrl.push = acc && is_open && !full;
  assign cell_ctrl.pop  = acc && is_close && !empty;

  // State after this byte, before the end-of-string clear.
  always_comb begin
    count_new  = count_q;
    failed_new = failed_q;
    ovf_new    = ovf_q;
    if (is_open) begin
      if (full) begin
        ovf_new = 1'b1;
      end else begin
        count_new = count_q + CntW'(1);
      end
    end else if (is_close) begin
      if (empty) begin
        failed_new = ERR_EMPTY;
      end else begin
        count_new = count_q - CntW'(1);
        if (kind_w[0] != ck) begin
          failed_new = ERR_MISMATCH;
        end
      end
    end
  end

  // Result of this byte; a sticky failure wins over brackets left open.
  always_comb begin
    err_res = failed_new;
    if (in_item_i.last_byte && (failed_new == ERR_NONE) && (count_new != '0)) begin
      err_res = ERR_OPEN;
    end
    depth_ext                   = {8'd0, count_new};
    out_item_d.done_res         = in_item_i.last_byte;
    out_item_d.balanced         = in_item_i.last_byte && (err_res == ERR_NONE);
    out_item_d.error_code       = err_res;
    out_item_d.overflow_seen    = ovf_new;
    out_item_d.open_depth       = depth_ext[7:0];
  end

  // Next state: update on an accepted item, clear at the end of a string.
  always_comb begin
    count_d  = count_q;
    failed_d = failed_q;
    ovf_d    = ovf_q;
    if (acc) begin
      if (in_item_i.last_byte) begin
        count_d  = '0;
        failed_d = ERR_NONE;
        ovf_d    = 1'b0;
      end else begin
        count_d  = count_new;
        failed_d = failed_new;
        ovf_d    = ovf_new;
      end
    end
  end

  // Output register valid: loaded on accept, freed when taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (acc) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      failed_q    <= ERR_NONE;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      failed_q    <= failed_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_item_o  = out_item_q;
  assign out_valid_o = out_valid_q;

  // Row of stack cells; cell 0 holds the top entry.
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    kind_e above, below;
    if (i == 0) begin : g_top
      assign above = ok;
    end else begin : g_mid
      assign above = kind_w[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign below = kind_w[i];
    end else begin : g_up
      assign below = kind_w[i+1];
    end
    bbc_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl),
      .above_i (above),
      .below_i (below),
      .kind_o  (kind_w[i])
    );
  end

  // The fill count never passes the number of cells.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(STACK_DEPTH))
    else $error("stack fill count exceeds depth");

  // Every accepted item leaves a result in the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> out_valid_o)
    else $error("accepted item produced no result");

  // The end of a string returns the checker to its clean state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && in_item_i.last_byte) |=>
      (count_q == '0) && (failed_q == ERR_NONE) && !ovf_q)
    else $error("state not cleared after last byte");

  // A failure stays until the string ends.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((failed_q != ERR_NONE) && !(acc && in_item_i.last_byte)) |=>
      (failed_q == $past(failed_q)) && (count_q == $past(count_q)))
    else $error("sticky failure changed within a string");

endmodule

`default_nettype wire
